/* sv/tiled_background_threshold_top_defines.svh */
// assertion macros for the tiled background threshold block
`ifndef TILED_BACKGROUND_THRESHOLD_TOP_DEFINES_SVH
`define TILED_BACKGROUND_THRESHOLD_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TBT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tbt_pkg.sv */
`default_nettype none
package tbt_pkg;

    localparam int GRID_DIM_DEF = 64;

    localparam int COORD_W = 12;
    localparam int PIX_W   = 16;
    localparam int GIDX_W  = 6;
    localparam int GVAL_W  = 24;
    localparam int LEVEL_W = 16;
    localparam int TILE_W  = 9;
    localparam int MULT_W  = 12;
    localparam int SUM_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_VAL_W = 12;

    localparam int TILE_MIN = 2;
    localparam int TILE_MAX = 256;
    localparam logic [TILE_W-1:0] TILE_RESET = 9'd64;
    localparam logic [MULT_W-1:0] MULT_RESET = 12'd768;

    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_WR_BG    = 2'd1;
    localparam logic [1:0] OP_WR_SIG   = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_MULT = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [PIX_W-1:0]   pixel_value;
        logic [GIDX_W-1:0]  grid_col;
        logic [GIDX_W-1:0]  grid_row;
        logic [GVAL_W-1:0]  grid_value;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] background_level;
        logic [LEVEL_W-1:0] sigma_level;
        logic               above;
        logic               out_of_grid;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } cfg_t;

endpackage
`default_nettype wire

/* sv/tbt_stream_if.sv */
`default_nettype none
interface tbt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/tbt_divider.sv */
`default_nettype none
module tbt_divider #(
    parameter int NUM_BITS = 12,
    parameter int REM_W    = 9,
    parameter int STEPS    = 4
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [REM_W-1:0]    rem_in,
    input  wire logic [NUM_BITS-1:0] num_in,
    input  wire logic [REM_W-1:0]    divisor,
    output logic      [NUM_BITS-1:0] quo,
    output logic      [REM_W-1:0]    rem
);
    localparam int STAGES = NUM_BITS / STEPS;

    logic [REM_W-1:0]    rem_reg   [STAGES];
    logic [NUM_BITS-1:0] work_reg  [STAGES];
    logic [REM_W-1:0]    rem_next  [STAGES];
    logic [NUM_BITS-1:0] work_next [STAGES];

    // restoring division, STEPS quotient bits per stage
    always_comb
    begin
        logic [REM_W-1:0]    r;
        logic [REM_W:0]      sh;
        logic [NUM_BITS-1:0] w;
        for (int s = 0; s < STAGES; s++)
        begin
            if (s == 0)
            begin
                r = rem_in;
                w = num_in;
            end
            else
            begin
                r = rem_reg[s-1];
                w = work_reg[s-1];
            end
            for (int k = 0; k < STEPS; k++)
            begin
                sh = {r, w[NUM_BITS-1]};
                w  = {w[NUM_BITS-2:0], 1'b0};
                if (sh >= {1'b0, divisor})
                begin
                    sh   = sh - {1'b0, divisor};
                    w[0] = 1'b1;
                end
                r = sh[REM_W-1:0];
            end
            rem_next[s]  = r;
            work_next[s] = w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                work_reg[s] <= work_next[s];
            end
        end
    end

    assign quo = work_reg[STAGES-1];
    assign rem = rem_reg[STAGES-1];
endmodule
`default_nettype wire

/* sv/tbt_grid_mem.sv */
`default_nettype none
module tbt_grid_mem
    import tbt_pkg::*;
#(
    parameter int DEPTH = GRID_DIM_DEF * GRID_DIM_DEF,
    parameter int AW    = $clog2(GRID_DIM_DEF * GRID_DIM_DEF)
) (
    input  wire logic                        clk,
    input  wire logic                        rd_en,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [GVAL_W-1:0]           wr_data,
    input  wire logic [2:0][AW-1:0]          rd_addr,
    output logic      [2:0][GVAL_W-1:0]      rd_data
);
    // one copy per read port, all written together
    for (genvar r = 0; r < 3; r++)
    begin : g_copy
        logic [GVAL_W-1:0] mem [DEPTH];
        logic [GVAL_W-1:0] rd_data_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en)
            begin
                rd_data_reg <= mem[rd_addr[r]];
            end
        end

        assign rd_data[r] = rd_data_reg;
    end
endmodule
`default_nettype wire

/* sv/tbt_plane.sv */
`default_nettype none
module tbt_plane
    import tbt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [2:0][GVAL_W-1:0]  corner,
    input  wire logic [2:0][TILE_W-1:0]  weight,
    output logic      [SUM_W-1:0]        sum
);
    localparam int PROD_W = GVAL_W + TILE_W;

    logic [2:0][PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [PROD_W:0]        sum_next;

    // weights add up to the tile size, so the sum fits SUM_W
    assign sum_next = (PROD_W+1)'(prod_reg[0]) + (PROD_W+1)'(prod_reg[1])
                    + (PROD_W+1)'(prod_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= PROD_W'(corner[i]) * PROD_W'(weight[i]);
            end
            sum_reg <= sum_next[SUM_W-1:0];
        end
    end

    assign sum = sum_reg;
endmodule
`default_nettype wire

/* sv/tiled_background_threshold_top.sv */
`default_nettype none
// Pixel classifier against a tiled background and sigma model. Each item is
// either a pixel to classify or a write into the background or sigma grid;
// every item returns exactly one result, in order. One item is accepted per
// cycle while the output is not stalled: the pipeline has two 3-stage
// coordinate dividers, replicated grid memories (three copies per grid, so
// the three triangle corners are read in parallel), a 2-stage plane
// multiply-add and two 4-stage level dividers. A stall on the output
// freezes the whole pipeline. Configuration is taken at any time but must
// only change while the block is empty.
module tiled_background_threshold_top
    import tbt_pkg::*;
#(
    parameter int GRID_DIM = GRID_DIM_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tbt_stream_if.sink   in_item,
    tbt_stream_if.source out_item,
    tbt_stream_if.sink   cfg
);
    localparam int IW = $clog2(GRID_DIM);
    localparam int AW = $clog2(GRID_DIM * GRID_DIM);
    localparam int CMP_W = 45;
    localparam logic [COORD_W-1:0] GX_LIMIT = COORD_W'(GRID_DIM - 1);

    typedef struct packed {
        logic [1:0]         op;
        logic [PIX_W-1:0]   pixel_value;
        logic [GIDX_W-1:0]  grid_col;
        logic [GIDX_W-1:0]  grid_row;
        logic [GVAL_W-1:0]  grid_value;
        logic               lt_x;
        logic               lt_y;
        logic [TILE_W-1:0]  off_x;
        logic [TILE_W-1:0]  off_y;
    } side_t;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] ix,
                                                 input logic [IW-1:0] iy);
        return AW'(ix) * AW'(GRID_DIM) + AW'(iy);
    endfunction

    logic [TILE_W-1:0] tile_reg;
    logic [MULT_W-1:0] mult_reg;
    logic [TILE_W-1:0] m;
    logic [TILE_W-2:0] mh;
    logic              adv;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_reg <= TILE_RESET;
            mult_reg <= MULT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                CFG_TILE_SIZE:  tile_reg <= cfg.data.value[TILE_W-1:0];
                CFG_SIGMA_MULT: mult_reg <= cfg.data.value;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (tile_reg < TILE_W'(TILE_MIN))
        begin
            m = TILE_W'(TILE_MIN);
        end
        else if (tile_reg > TILE_W'(TILE_MAX))
        begin
            m = TILE_W'(TILE_MAX);
        end
        else
        begin
            m = tile_reg;
        end
    end

    assign mh = m[TILE_W-1:1];

    // valid chain
    logic       s1_vld_reg;
    logic [2:0] dv_reg;
    logic       g_vld_reg;
    logic       m_vld_reg;
    logic [1:0] p_vld_reg;
    logic [3:0] l_vld_reg;
    logic       out_vld_reg;

    assign adv           = !out_vld_reg || out_item.ready;
    assign in_item.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            dv_reg      <= '0;
            g_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            p_vld_reg   <= '0;
            l_vld_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= in_item.valid;
            dv_reg      <= {dv_reg[1:0], s1_vld_reg};
            g_vld_reg   <= dv_reg[2];
            m_vld_reg   <= g_vld_reg;
            p_vld_reg   <= {p_vld_reg[0], m_vld_reg};
            l_vld_reg   <= {l_vld_reg[2:0], p_vld_reg[1]};
            out_vld_reg <= l_vld_reg[3];
        end
    end

    // input register and tile offset
    item_t              s1_reg;
    side_t              s1_side;
    logic [COORD_W-1:0] t_x;
    logic [COORD_W-1:0] t_y;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= in_item.data;
        end
    end

    assign t_x = s1_reg.pixel_x - COORD_W'(mh);
    assign t_y = s1_reg.pixel_y - COORD_W'(mh);

    always_comb
    begin
        s1_side.op          = s1_reg.op;
        s1_side.pixel_value = s1_reg.pixel_value;
        s1_side.grid_col    = s1_reg.grid_col;
        s1_side.grid_row    = s1_reg.grid_row;
        s1_side.grid_value  = s1_reg.grid_value;
        s1_side.lt_x        = s1_reg.pixel_x < COORD_W'(mh);
        s1_side.lt_y        = s1_reg.pixel_y < COORD_W'(mh);
        s1_side.off_x       = TILE_W'(s1_reg.pixel_x) + m - TILE_W'(mh);
        s1_side.off_y       = TILE_W'(s1_reg.pixel_y) + m - TILE_W'(mh);
    end

    // coordinate dividers
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
    logic [TILE_W-1:0]  rx;
    logic [TILE_W-1:0]  ry;
    side_t              dside_reg [3];

    tbt_divider #(.NUM_BITS(COORD_W), .REM_W(TILE_W), .STEPS(4)) u_div_x (
        .clk     (clk),
        .en      (adv),
        .rem_in  ('0),
        .num_in  (t_x),
        .divisor (m),
        .quo     (qx),
        .rem     (rx)
    );

    tbt_divider #(.NUM_BITS(COORD_W), .REM_W(TILE_W), .STEPS(4)) u_div_y (
        .clk     (clk),
        .en      (adv),
        .rem_in  ('0),
        .num_in  (t_y),
        .divisor (m),
        .quo     (qy),
        .rem     (ry)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dside_reg[0] <= s1_side;
            dside_reg[1] <= dside_reg[0];
            dside_reg[2] <= dside_reg[1];
        end
    end

    // cell, triangle, weights and addresses
    side_t              ds;
    logic [COORD_W-1:0] gx;
    logic [COORD_W-1:0] gy;
    logic [TILE_W-1:0]  dx;
    logic [TILE_W-1:0]  dy;
    logic               upper;
    logic [IW-1:0]      gxi;
    logic [IW-1:0]      gyi;
    logic [IW-1:0]      gxi1;
    logic [IW-1:0]      gyi1;
    logic               wr_ok;

    assign ds    = dside_reg[2];
    assign gx    = ds.lt_x ? '0 : qx;
    assign gy    = ds.lt_y ? '0 : qy;
    assign dx    = ds.lt_x ? ds.off_x : rx;
    assign dy    = ds.lt_y ? ds.off_y : ry;
    assign upper = dy > dx;
    assign gxi   = gx[IW-1:0];
    assign gyi   = gy[IW-1:0];
    assign gxi1  = gxi + 1'b1;
    assign gyi1  = gyi + 1'b1;
    assign wr_ok = 32'(ds.grid_col) < GRID_DIM && 32'(ds.grid_row) < GRID_DIM;

    logic [2:0][AW-1:0]     g_addr_reg;
    logic [2:0][TILE_W-1:0] g_w_reg;
    logic                   g_oog_reg;
    logic [1:0]             g_op_reg;
    logic [PIX_W-1:0]       g_pv_reg;
    logic [AW-1:0]          g_wr_addr_reg;
    logic [GVAL_W-1:0]      g_wr_data_reg;
    logic                   g_wr_bg_reg;
    logic                   g_wr_sig_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_addr_reg[0] <= cell_addr(gxi, gyi);
            g_addr_reg[1] <= cell_addr(gxi1, gyi1);
            g_addr_reg[2] <= upper ? cell_addr(gxi, gyi1) : cell_addr(gxi1, gyi);
            g_w_reg[0]    <= m - (upper ? dy : dx);
            g_w_reg[1]    <= upper ? dx : dy;
            g_w_reg[2]    <= upper ? dy - dx : dx - dy;
            g_oog_reg     <= gx >= GX_LIMIT || gy >= GX_LIMIT;
            g_op_reg      <= ds.op;
            g_pv_reg      <= ds.pixel_value;
            g_wr_addr_reg <= cell_addr(IW'(ds.grid_col), IW'(ds.grid_row));
            g_wr_data_reg <= ds.grid_value;
            g_wr_bg_reg   <= ds.op == OP_WR_BG && wr_ok;
            g_wr_sig_reg  <= ds.op == OP_WR_SIG && wr_ok;
        end
    end

    // grid memories
    logic [2:0][GVAL_W-1:0] bg_rd;
    logic [2:0][GVAL_W-1:0] sig_rd;

    tbt_grid_mem #(.DEPTH(GRID_DIM * GRID_DIM), .AW(AW)) u_bg_mem (
        .clk     (clk),
        .rd_en   (adv),
        .wr_en   (adv && g_vld_reg && g_wr_bg_reg),
        .wr_addr (g_wr_addr_reg),
        .wr_data (g_wr_data_reg),
        .rd_addr (g_addr_reg),
        .rd_data (bg_rd)
    );

    tbt_grid_mem #(.DEPTH(GRID_DIM * GRID_DIM), .AW(AW)) u_sig_mem (
        .clk     (clk),
        .rd_en   (adv),
        .wr_en   (adv && g_vld_reg && g_wr_sig_reg),
        .wr_addr (g_wr_addr_reg),
        .wr_data (g_wr_data_reg),
        .rd_addr (g_addr_reg),
        .rd_data (sig_rd)
    );

    logic [2:0][TILE_W-1:0] m_w_reg;
    logic                   m_oog_reg;
    logic                   m_cls_reg;
    logic [PIX_W-1:0]       m_pv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_w_reg   <= g_w_reg;
            m_oog_reg <= g_oog_reg;
            m_cls_reg <= g_op_reg == OP_CLASSIFY;
            m_pv_reg  <= g_pv_reg;
        end
    end

    // plane interpolation
    logic [SUM_W-1:0] nb;
    logic [SUM_W-1:0] ns;

    tbt_plane u_bg_plane (
        .clk    (clk),
        .en     (adv),
        .corner (bg_rd),
        .weight (m_w_reg),
        .sum    (nb)
    );

    tbt_plane u_sig_plane (
        .clk    (clk),
        .en     (adv),
        .corner (sig_rd),
        .weight (m_w_reg),
        .sum    (ns)
    );

    logic             p_oog_reg [2];
    logic             p_cls_reg [2];
    logic [PIX_W-1:0] p_pv_reg  [2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_oog_reg[0] <= m_oog_reg;
            p_cls_reg[0] <= m_cls_reg;
            p_pv_reg[0]  <= m_pv_reg;
            p_oog_reg[1] <= p_oog_reg[0];
            p_cls_reg[1] <= p_cls_reg[0];
            p_pv_reg[1]  <= p_pv_reg[0];
        end
    end

    // level dividers: floor(floor(N / 256) / m)
    logic [LEVEL_W-1:0] bg_lvl;
    logic [LEVEL_W-1:0] sig_lvl;
    logic [TILE_W-1:0]  bg_rem;
    logic [TILE_W-1:0]  sig_rem;

    tbt_divider #(.NUM_BITS(LEVEL_W), .REM_W(TILE_W), .STEPS(4)) u_div_bg (
        .clk     (clk),
        .en      (adv),
        .rem_in  (TILE_W'(nb[SUM_W-1:SUM_W-8])),
        .num_in  (nb[SUM_W-9:8]),
        .divisor (m),
        .quo     (bg_lvl),
        .rem     (bg_rem)
    );

    tbt_divider #(.NUM_BITS(LEVEL_W), .REM_W(TILE_W), .STEPS(4)) u_div_sig (
        .clk     (clk),
        .en      (adv),
        .rem_in  (TILE_W'(ns[SUM_W-1:SUM_W-8])),
        .num_in  (ns[SUM_W-9:8]),
        .divisor (m),
        .quo     (sig_lvl),
        .rem     (sig_rem)
    );

    // threshold compare: v * 65536 * m > 256 * Nbg + mult * Nsig
    logic [PIX_W+TILE_W-1:0]  c1_lhs_reg;
    logic [MULT_W+SUM_W-1:0]  c1_smp_reg;
    logic [SUM_W-1:0]         c1_nb_reg;
    logic                     c2_above_reg;
    logic                     c3_above_reg;
    logic                     c4_above_reg;
    logic [CMP_W-1:0]         lhs_full;
    logic [CMP_W-1:0]         rhs_full;

    assign lhs_full = {CMP_W'(c1_lhs_reg)} << 16;
    assign rhs_full = (CMP_W'(c1_nb_reg) << 8) + CMP_W'(c1_smp_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_lhs_reg   <= (PIX_W+TILE_W)'(p_pv_reg[1]) * (PIX_W+TILE_W)'(m);
            c1_smp_reg   <= (MULT_W+SUM_W)'(mult_reg) * (MULT_W+SUM_W)'(ns);
            c1_nb_reg    <= nb;
            c2_above_reg <= lhs_full > rhs_full;
            c3_above_reg <= c2_above_reg;
            c4_above_reg <= c3_above_reg;
        end
    end

    logic l_oog_reg [4];
    logic l_cls_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_oog_reg[0] <= p_oog_reg[1];
            l_cls_reg[0] <= p_cls_reg[1];
            for (int i = 1; i < 4; i++)
            begin
                l_oog_reg[i] <= l_oog_reg[i-1];
                l_cls_reg[i] <= l_cls_reg[i-1];
            end
        end
    end

    // output register
    result_t out_data_reg;
    result_t out_next;
    logic    live;

    assign live = l_cls_reg[3] && !l_oog_reg[3];

    always_comb
    begin
        out_next.background_level = live ? bg_lvl : '0;
        out_next.sigma_level      = live ? sig_lvl : '0;
        out_next.above            = live && c4_above_reg;
        out_next.out_of_grid      = l_cls_reg[3] && l_oog_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_item.valid = out_vld_reg;
    assign out_item.data  = out_data_reg;
endmodule
`default_nettype wire

/* sv/tbt_checker.sv */
`default_nettype none
`include "tiled_background_threshold_top_defines.svh"
module tbt_checker
    import tbt_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_ready,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire result_t out_data
);
    logic oog_clean;

    assign oog_clean = !out_data.above && out_data.background_level == '0
                    && out_data.sigma_level == '0;

    `TBT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `TBT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed")
    `TBT_ASSERT_IMPL(a_in_ready, !out_valid || out_ready, in_ready, "input refused")
    `TBT_ASSERT_IMPL(a_oog_zero, out_valid && out_data.out_of_grid, oog_clean, "oog not cleared")
endmodule

bind tiled_background_threshold_top tbt_checker u_tbt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .out_data  (out_item.data)
);
`default_nettype wire

/* tb/tiled_background_threshold_top_test.sv */
`timescale 1ns / 1ps

import tbt_pkg::*;

class threshold_scoreboard;

    logic [GVAL_W-1:0] bg_grid [GRID_DIM_DEF][GRID_DIM_DEF];
    logic [GVAL_W-1:0] sig_grid [GRID_DIM_DEF][GRID_DIM_DEF];
    logic [TILE_W-1:0] tile_reg;
    logic [MULT_W-1:0] mult_reg;
    result_t           expected_q[$];
    int                errors;

    function new();
        tile_reg = TILE_RESET;
        mult_reg = MULT_RESET;
        errors = 0;
    endfunction

    function int unsigned tile_side();
        if (tile_reg < TILE_MIN)
            return TILE_MIN;
        if (tile_reg > TILE_MAX)
            return TILE_MAX;
        return tile_reg;
    endfunction

    function void locate(input int unsigned p, input int unsigned m,
                         output int unsigned idx, output int unsigned off);
        int unsigned h;
        h = m / 2;
        if (p < h)
        begin
            idx = 0;
            off = p + m - h;
        end
        else
        begin
            idx = (p - h) / m;
            off = p - h - idx * m;
        end
    endfunction

    function longint unsigned plane(input bit use_sig, input int unsigned gx,
                                    input int unsigned gy, input int unsigned dx,
                                    input int unsigned dy, input int unsigned m);
        longint unsigned a, b, c, d;
        a = use_sig ? sig_grid[gx][gy] : bg_grid[gx][gy];
        d = use_sig ? sig_grid[gx+1][gy+1] : bg_grid[gx+1][gy+1];
        if (dy > dx)
        begin
            c = use_sig ? sig_grid[gx][gy+1] : bg_grid[gx][gy+1];
            return a * (m - dy) + c * (dy - dx) + d * dx;
        end
        b = use_sig ? sig_grid[gx+1][gy] : bg_grid[gx+1][gy];
        return a * (m - dx) + b * (dx - dy) + d * dy;
    endfunction

    function void note_config(cfg_t c);
        if (c.index == CFG_TILE_SIZE)
            tile_reg = c.value[TILE_W-1:0];
        else if (c.index == CFG_SIGMA_MULT)
            mult_reg = c.value[MULT_W-1:0];
    endfunction

    function void note_item(item_t it);
        result_t r;
        int unsigned m, gx, gy, dx, dy;
        longint unsigned nb, ns, lhs, rhs;
        r = '0;
        if (it.op == OP_WR_BG)
            bg_grid[it.grid_col][it.grid_row] = it.grid_value;
        else if (it.op == OP_WR_SIG)
            sig_grid[it.grid_col][it.grid_row] = it.grid_value;
        else if (it.op == OP_CLASSIFY)
        begin
            m = tile_side();
            locate(it.pixel_x, m, gx, dx);
            locate(it.pixel_y, m, gy, dy);
            if (gx + 1 >= GRID_DIM_DEF || gy + 1 >= GRID_DIM_DEF)
                r.out_of_grid = 1'b1;
            else
            begin
                nb = plane(1'b0, gx, gy, dx, dy, m);
                ns = plane(1'b1, gx, gy, dx, dy, m);
                r.background_level = LEVEL_W'(nb / (256 * m));
                r.sigma_level = LEVEL_W'(ns / (256 * m));
                lhs = longint'(it.pixel_value) * 65536 * m;
                rhs = nb * 256 + longint'(mult_reg) * ns;
                r.above = lhs > rhs;
            end
        end
        expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
        result_t exp_r;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        if (got.background_level !== exp_r.background_level)
        begin
            $display("%0t: background_level expected %0d actual %0d", $time,
                     exp_r.background_level, got.background_level);
            errors++;
        end
        if (got.sigma_level !== exp_r.sigma_level)
        begin
            $display("%0t: sigma_level expected %0d actual %0d", $time,
                     exp_r.sigma_level, got.sigma_level);
            errors++;
        end
        if (got.above !== exp_r.above)
        begin
            $display("%0t: above expected %0d actual %0d", $time, exp_r.above, got.above);
            errors++;
        end
        if (got.out_of_grid !== exp_r.out_of_grid)
        begin
            $display("%0t: out_of_grid expected %0d actual %0d", $time,
                     exp_r.out_of_grid, got.out_of_grid);
            errors++;
        end
    endfunction
endclass

module tiled_background_threshold_top_test;
    import tbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_W = $bits(item_t);

    logic clk;
    logic rst_n;
    bit   hold_output;
    bit   no_gaps;
    bit   bg_written [GRID_DIM_DEF][GRID_DIM_DEF];
    bit   sig_written [GRID_DIM_DEF][GRID_DIM_DEF];
    int   quiet_cycles;
    threshold_scoreboard sb;

    tbt_stream_if #(.T(item_t))   in_item();
    tbt_stream_if #(.T(result_t)) out_item();
    tbt_stream_if #(.T(cfg_t))    cfg();

    tiled_background_threshold_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_item(in_item),
        .out_item(out_item),
        .cfg(cfg)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function bit cell_loaded(int unsigned gx, int unsigned gy);
        if (gx + 1 >= GRID_DIM_DEF || gy + 1 >= GRID_DIM_DEF)
            return 1'b0;
        return bg_written[gx][gy] && bg_written[gx+1][gy] && bg_written[gx][gy+1]
            && bg_written[gx+1][gy+1] && sig_written[gx][gy] && sig_written[gx+1][gy]
            && sig_written[gx][gy+1] && sig_written[gx+1][gy+1];
    endfunction

    task automatic send_item(item_t it);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_item.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_item.valid <= 1'b1;
        in_item.data <= it;
        if (it.op == OP_WR_BG)
            bg_written[it.grid_col][it.grid_row] = 1'b1;
        else if (it.op == OP_WR_SIG)
            sig_written[it.grid_col][it.grid_row] = 1'b1;
        do
            @(posedge clk);
        while (!in_item.ready);
    endtask

    task automatic write_entry(logic [1:0] op, int col, int row, logic [GVAL_W-1:0] v);
        item_t it;
        it = ITEM_W'({$urandom, $urandom, $urandom});
        it.op = op;
        it.grid_col = GIDX_W'(col);
        it.grid_row = GIDX_W'(row);
        it.grid_value = v;
        send_item(it);
    endtask

    task automatic classify(int x, int y, logic [PIX_W-1:0] v);
        item_t it;
        it = ITEM_W'({$urandom, $urandom, $urandom});
        it.op = OP_CLASSIFY;
        it.pixel_x = COORD_W'(x);
        it.pixel_y = COORD_W'(y);
        it.pixel_value = v;
        send_item(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_VAL_W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.data <= '{index: idx, value: v};
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_item.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_classify();
        int unsigned m, x, y, gx, gy, dx, dy, maxg;
        bit found;
        m = sb.tile_side();
        maxg = (4095 - m / 2) / m;
        found = 1'b0;
        for (int t = 0; t < 30 && !found; t++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                gx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 62);
                gy = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 62);
                if (gx <= maxg && gy <= maxg && cell_loaded(gx, gy))
                begin
                    x = (gx == 0) ? $urandom_range(0, m / 2 + m - 1)
                                  : gx * m + m / 2 + $urandom_range(0, m - 1);
                    y = (gy == 0) ? $urandom_range(0, m / 2 + m - 1)
                                  : gy * m + m / 2 + $urandom_range(0, m - 1);
                    found = x <= 4095 && y <= 4095;
                end
            end
            else
            begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
                sb.locate(x, m, gx, dx);
                sb.locate(y, m, gy, dy);
                found = gx + 1 >= GRID_DIM_DEF || gy + 1 >= GRID_DIM_DEF
                    || cell_loaded(gx, gy);
            end
        end
        if (!found)
        begin
            x = 0;
            y = 0;
        end
        classify(x, y, ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom));
    endtask

    task automatic random_grid_write();
        int col, row;
        logic [GVAL_W-1:0] v;
        col = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 63);
        row = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = GVAL_W'($urandom_range(0, 255));
            default: v = GVAL_W'($urandom);
        endcase
        write_entry(($urandom_range(0, 1) != 0) ? OP_WR_SIG : OP_WR_BG, col, row, v);
    endtask

    task automatic random_phase(int count, bit pressure);
        item_t it;
        for (int i = 0; i < count; i++)
        begin
            if (pressure && i == count / 2)
                hold_output = 1'b1;
            case ($urandom_range(0, 19))
                0: begin
                    it = ITEM_W'({$urandom, $urandom, $urandom});
                    it.op = OP_NONE;
                    send_item(it);
                end
                1, 2, 3, 4, 5, 6: random_grid_write();
                default: random_classify();
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        hold_output = 1'b0;
        no_gaps = 1'b0;
        in_item.valid = 1'b0;
        in_item.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int c = 0; c < 2; c++)
            for (int r = 0; r < 2; r++)
            begin
                write_entry(OP_WR_BG, c, r, (c == r) ? '1 : '0);
                write_entry(OP_WR_SIG, c, r, (c == 0) ? 24'h000100 : 24'h7FFF00);
            end
        for (int c = 62; c < 64; c++)
        begin
            write_entry(OP_WR_BG, c, 62, 24'hABCDEF);
            write_entry(OP_WR_BG, c, 63, 24'h123456);
            write_entry(OP_WR_SIG, c, 62, 24'h000A00);
            write_entry(OP_WR_SIG, c, 63, 24'h001000);
        end
        classify(0, 0, 16'h0000);
        classify(32, 32, 16'hFFFF);
        classify(40, 90, 16'h8000);
        classify(90, 40, 16'h7FFF);
        classify(95, 95, 16'h0001);
        classify(62 * 64 + 32 + 10, 62 * 64 + 32 + 40, 16'hFFFF);
        classify(4095, 4095, 16'hFFFF);
        classify(4095, 0, 16'h1234);
        write_entry(OP_NONE, 63, 63, '1);

        wait_drained();
        write_reg(CFG_TILE_SIZE, 12'd2);
        write_reg(CFG_SIGMA_MULT, 12'd0);
        random_phase(110, 1'b0);

        wait_drained();
        write_reg(CFG_TILE_SIZE, 12'd256);
        write_reg(CFG_SIGMA_MULT, 12'd4095);
        random_phase(110, 1'b1);

        wait_drained();
        no_gaps = 1'b1;
        write_reg(CFG_TILE_SIZE, 12'd0);
        write_reg(CFG_SIGMA_MULT, 12'd768);
        random_phase(90, 1'b0);

        wait_drained();
        no_gaps = 1'b0;
        write_reg(CFG_TILE_SIZE, 12'hDFF);
        write_reg(CFG_SIGMA_MULT, 12'd256);
        random_phase(90, 1'b0);

        wait_drained();
        write_reg(CFG_TILE_SIZE, 12'd37);
        write_reg(CFG_SIGMA_MULT, 12'd1000);
        random_phase(110, 1'b0);

        wait_drained();
        write_reg(CFG_TILE_SIZE, 12'd3);
        write_reg(CFG_SIGMA_MULT, 12'($urandom));
        random_phase(110, 1'b0);

        wait_drained();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int n;
        out_item.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                out_item.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    out_item.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            out_item.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_item.valid && in_item.ready)
                sb.note_item(in_item.data);
            if (cfg.valid && cfg.ready)
                sb.note_config(cfg.data);
            if (out_item.valid && out_item.ready)
                sb.check_result(out_item.data);
            if ((in_item.valid && in_item.ready) || (cfg.valid && cfg.ready)
                || (out_item.valid && out_item.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        else
            quiet_cycles <= 0;
    end
endmodule

/* tiled_background_threshold_top.f */
+incdir+sv
sv/tbt_pkg.sv
sv/tbt_stream_if.sv
sv/tbt_divider.sv
sv/tbt_grid_mem.sv
sv/tbt_plane.sv
sv/tiled_background_threshold_top.sv
sv/tbt_checker.sv
tb/tiled_background_threshold_top_test.sv
